// ===== hdl/lcv_pkg.sv =====
// Package with the types, constants and ones' complement helper of the L4 checksum verifier.
`timescale 1ns / 1ps
`default_nettype none

package lcv_pkg;

    // Transport protocol kind reported with each result.
    typedef enum logic [1:0] {
        KIND_TCP   = 2'd0,
        KIND_UDP   = 2'd1,
        KIND_OTHER = 2'd2
    } l4_kind_t;

    // One registered input beat.
    typedef struct packed {
        logic [15:0] data_word;
        logic        last;
    } lcv_beat_t;

    // One result item.
    typedef struct packed {
        logic [15:0] checksum_value;
        l4_kind_t    l4_kind;
        logic        length_error;
    } lcv_result_t;

    localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;
    localparam logic [14:0] MAX_INDEX       = 15'h7fff;
    localparam logic [14:0] IDX_IHL         = 15'd0;
    localparam logic [14:0] IDX_TOTAL_LEN   = 15'd1;
    localparam logic [14:0] IDX_PROTOCOL    = 15'd4;
    localparam logic [14:0] IDX_ADDR_FIRST  = 15'd6;
    localparam logic [14:0] IDX_ADDR_LAST   = 15'd9;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [15:0] RECEIVED_FULL   = 16'h8000;

    // Ones' complement 16-bit add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lcv_in_if.sv =====
// Stream interface that carries packet words into the checksum verifier.
`timescale 1ns / 1ps
`default_nettype none

interface lcv_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_word;
    logic        last;

    modport source (output valid, output data_word, output last, input ready);
    modport sink   (input valid, input data_word, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/lcv_out_if.sv =====
// Stream interface that carries checksum results out of the verifier.
`timescale 1ns / 1ps
`default_nettype none

interface lcv_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum_value;
    logic [1:0]  l4_kind;
    logic        length_error;

    modport source (output valid, output checksum_value, output l4_kind,
                    output length_error, input ready);
    modport sink   (input valid, input checksum_value, input l4_kind,
                    input length_error, output ready);
endinterface

`default_nettype wire

// ===== hdl/l4_checksum_verifier.sv =====
// Top level of the TCP/UDP checksum verifier for IPv4 packets.
`timescale 1ns / 1ps
`default_nettype none

// The verifier takes an IPv4 packet as 16-bit big-endian words on pkt, one word
// per beat starting with the first IP header word, with last set on the final
// word. It keeps the header length, total length and protocol from the header,
// adds the source and destination addresses and the transport bytes into a
// ones' complement sum (words past the total length are ignored, an odd final
// byte is padded with zero), and on the final word adds the pseudo-header
// protocol and transport length. One result beat on res follows each packet:
// checksum_value is the complemented sum and reads zero for a correct packet,
// l4_kind is 0 for TCP, 1 for UDP and 2 for any other protocol, and
// length_error flags a header length under five words or a stream shorter than
// the total length. The block accepts one word in every clock cycle except while a
// final word is held as below. A word passes an input register, then end-around-carry
// adds into the packet state and the result register, and a result shows on res once
// its final word is loaded into the result register. Words that are not final keep
// flowing while a finished result waits on res; only the next final word holds in the
// input register until the result register is free, so the ready signal on pkt drops
// only while a final word waits, the result register is full and res is stalled.
module l4_checksum_verifier (
    input  wire logic clk,
    input  wire logic rst_n,
    lcv_in_if.sink    pkt,
    lcv_out_if.source res
);
    import lcv_pkg::*;

    logic        beat_valid;
    lcv_beat_t   beat;
    logic        slot_free;
    logic        advance;
    logic        load;
    lcv_result_t result;

    // A registered word moves on at once unless it is a final word and the
    // result register cannot take its result yet.
    assign advance = beat_valid && (slot_free || !beat.last);
    assign load    = advance && beat.last;

    lcv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    lcv_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .beat   (beat),
        .result (result)
    );

    lcv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .result    (result),
        .res       (res),
        .slot_free (slot_free)
    );

endmodule

`default_nettype wire

// ===== hdl/lcv_in_stage.sv =====
// Input register stage that captures one packet word per beat.
`timescale 1ns / 1ps
`default_nettype none

module lcv_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lcv_in_if.sink                 pkt,
    input  wire logic              advance,
    output logic                   beat_valid,
    output lcv_pkg::lcv_beat_t     beat
);
    import lcv_pkg::*;

    logic      valid_reg;
    lcv_beat_t beat_reg;
    logic      take;

    // The stage can take a new beat when empty or when its beat moves on.
    assign pkt.ready  = !valid_reg || advance;
    assign take       = pkt.valid && pkt.ready;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg.data_word <= pkt.data_word;
            beat_reg.last      <= pkt.last;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcv_accum.sv =====
// Header tracking, ones' complement accumulation and result computation.
`timescale 1ns / 1ps
`default_nettype none

module lcv_accum (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire lcv_pkg::lcv_beat_t beat,
    output lcv_pkg::lcv_result_t    result
);
    import lcv_pkg::*;

    logic [14:0] word_index_reg,      word_index_next;
    logic        index_full_reg,      index_full_next;
    logic [3:0]  header_words_reg,    header_words_next;
    logic [15:0] packet_length_reg,   packet_length_next;
    logic [7:0]  protocol_number_reg, protocol_number_next;
    logic [15:0] running_sum_reg,     running_sum_next;

    logic [3:0]  hdr_eff;
    logic [14:0] payload_start;
    logic        live;
    logic        addr_word;
    logic        in_payload;
    logic [15:0] odd_end;
    logic        add_en;
    logic [15:0] addend;
    logic [15:0] received;
    logic [15:0] transport_len;
    logic [15:0] pseudo_sum;

    always_comb
    begin
        live = !index_full_reg;

        header_words_next    = (live && word_index_reg == IDX_IHL)
                               ? beat.data_word[11:8] : header_words_reg;
        packet_length_next   = (live && word_index_reg == IDX_TOTAL_LEN)
                               ? beat.data_word : packet_length_reg;
        protocol_number_next = (live && word_index_reg == IDX_PROTOCOL)
                               ? beat.data_word[7:0] : protocol_number_reg;

        hdr_eff       = (header_words_next < MIN_HDR_WORDS) ? MIN_HDR_WORDS
                                                            : header_words_next;
        payload_start = {10'b0, hdr_eff, 1'b0};

        // Source and destination addresses are header words six to nine.
        addr_word  = live && word_index_reg >= IDX_ADDR_FIRST
                          && word_index_reg <= IDX_ADDR_LAST;
        in_payload = live && word_index_reg >= payload_start;
        // Byte offset of the low byte of this word.
        odd_end    = {word_index_reg, 1'b1};

        add_en = 1'b0;
        addend = beat.data_word;
        if (addr_word)
        begin
            add_en = 1'b1;
        end
        else if (in_payload && odd_end < packet_length_next)
        begin
            add_en = 1'b1;
        end
        else if (in_payload && odd_end == packet_length_next)
        begin
            // Odd final byte is padded with a zero low byte.
            add_en = 1'b1;
            addend = {beat.data_word[15:8], 8'h00};
        end

        running_sum_next = add_en ? ones_add(running_sum_reg, addend) : running_sum_reg;

        index_full_next = index_full_reg || (word_index_reg == MAX_INDEX);
        word_index_next = (live && word_index_reg != MAX_INDEX)
                          ? word_index_reg + 15'd1 : word_index_reg;

        received      = index_full_next ? RECEIVED_FULL : {1'b0, word_index_next};
        transport_len = packet_length_next - {10'b0, hdr_eff, 2'b00};
        pseudo_sum    = ones_add(running_sum_next, {8'b0, protocol_number_next});

        result.checksum_value = ~ones_add(pseudo_sum, transport_len);
        if (protocol_number_next == PROTO_TCP)
        begin
            result.l4_kind = KIND_TCP;
        end
        else if (protocol_number_next == PROTO_UDP)
        begin
            result.l4_kind = KIND_UDP;
        end
        else
        begin
            result.l4_kind = KIND_OTHER;
        end
        result.length_error = (header_words_next < MIN_HDR_WORDS)
                           || ({received, 1'b0} < {1'b0, packet_length_next});
    end

    // All packet state returns to zero after the final word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg      <= '0;
            index_full_reg      <= 1'b0;
            header_words_reg    <= '0;
            packet_length_reg   <= '0;
            protocol_number_reg <= '0;
            running_sum_reg     <= '0;
        end
        else if (step)
        begin
            if (beat.last)
            begin
                word_index_reg      <= '0;
                index_full_reg      <= 1'b0;
                header_words_reg    <= '0;
                packet_length_reg   <= '0;
                protocol_number_reg <= '0;
                running_sum_reg     <= '0;
            end
            else
            begin
                word_index_reg      <= word_index_next;
                index_full_reg      <= index_full_next;
                header_words_reg    <= header_words_next;
                packet_length_reg   <= packet_length_next;
                protocol_number_reg <= protocol_number_next;
                running_sum_reg     <= running_sum_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcv_out_stage.sv =====
// Result register that holds one checksum result until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module lcv_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire lcv_pkg::lcv_result_t result,
    lcv_out_if.source                 res,
    output logic                      slot_free
);
    import lcv_pkg::*;

    logic        valid_reg;
    lcv_result_t result_reg;

    assign slot_free          = !valid_reg || res.ready;
    assign res.valid          = valid_reg;
    assign res.checksum_value = result_reg.checksum_value;
    assign res.l4_kind        = result_reg.l4_kind;
    assign res.length_error   = result_reg.length_error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcv_checker.sv =====
// Port-level assertions for the checksum verifier and their bind.
`timescale 1ns / 1ps
`default_nettype none

module lcv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pkt_valid,
    input wire logic        pkt_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [15:0] checksum_value,
    input wire logic [1:0]  l4_kind,
    input wire logic        length_error
);
    import lcv_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(checksum_value)
            && $stable(l4_kind) && $stable(length_error))
        else $error("stalled result changed");

    // The result kind is always one of the three defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (l4_kind == KIND_TCP) || (l4_kind == KIND_UDP)
            || (l4_kind == KIND_OTHER))
        else $error("undefined protocol kind");

    // With the result register empty, the input side must be open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> pkt_ready)
        else $error("input stalled with empty result register");

    // Input back-pressure only comes from a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_ready |-> res_valid && !res_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind l4_checksum_verifier lcv_checker u_lcv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pkt_valid      (pkt.valid),
    .pkt_ready      (pkt.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .checksum_value (res.checksum_value),
    .l4_kind        (res.l4_kind),
    .length_error   (res.length_error)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the IPv4 TCP/UDP checksum verifier.
`timescale 1ns / 1ps

module tb;
    import lcv_pkg::*;

    // Results pass the input and result registers, so a short drain covers the pipeline.
    localparam int DRAIN_CYCLES  = 10;
    // The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 1450;
    localparam int LONG_WORDS    = 32770;
    localparam int MAX_GAP       = 12;
    // Word offsets of the checksum field inside the transport header.
    localparam int TCP_CSUM_WORD = 8;
    localparam int UDP_CSUM_WORD = 3;

    // Packet state as the verifier keeps it between words.
    typedef struct packed {
        logic [14:0] word_no;
        logic [3:0]  ihl;
        logic [15:0] ip_len;
        logic [7:0]  proto;
        logic [15:0] sum;
        logic        capped;
    } pkt_state_t;

    logic clk;
    logic rst_n;

    lcv_in_if  pkt ();
    lcv_out_if res ();

    l4_checksum_verifier DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .res   (res)
    );

    // Running copy of the verifier state, advanced on every accepted input beat.
    pkt_state_t  live_state;
    // Results still owed by the verifier, oldest first.
    lcv_result_t pending_results[$];
    // Words of the packet that the current test is about to send.
    logic [15:0] frame[$];

    int    errors;
    int    words_accepted;
    int    in_gap_max;
    int    out_gap_max;
    int    cycle_count;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Ones' complement add: fold the carry out of bit 15 back into bit 0.
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] t;
        t = {16'h0, a} + {16'h0, b};
        t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
        return t[15:0];
    endfunction

    // A header length under five words is treated as the minimal 20-byte header.
    function automatic int hdr_words_of(input logic [3:0] ihl);
        return (ihl < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(ihl);
    endfunction

    // Advance the packet state by one input word.
    function automatic pkt_state_t take_word(input pkt_state_t s, input logic [15:0] w);
        int hdr_words;
        int offset;
        if (s.capped)
            return s;
        if (s.word_no == IDX_IHL)
            s.ihl = w[11:8];
        if (s.word_no == IDX_TOTAL_LEN)
            s.ip_len = w;
        if (s.word_no == IDX_PROTOCOL)
            s.proto = w[7:0];
        // Source and destination addresses go into the pseudo-header sum.
        if (s.word_no >= IDX_ADDR_FIRST && s.word_no <= IDX_ADDR_LAST)
            s.sum = fold_add(s.sum, w);
        hdr_words = hdr_words_of(s.ihl);
        if (int'(s.word_no) >= 2 * hdr_words) begin
            offset = 2 * int'(s.word_no);
            if (offset + 1 < int'(s.ip_len))
                s.sum = fold_add(s.sum, w);
            else if (offset + 1 == int'(s.ip_len))
                s.sum = fold_add(s.sum, {w[15:8], 8'h00});
        end
        if (s.word_no == MAX_INDEX)
            s.capped = 1'b1;
        else
            s.word_no = s.word_no + 15'd1;
        return s;
    endfunction

    // Result that the verifier gives when the word just taken was the final one.
    function automatic lcv_result_t close_packet(input pkt_state_t s);
        lcv_result_t r;
        int          received;
        logic [15:0] tlen;
        logic [15:0] acc;
        received = s.capped ? int'(RECEIVED_FULL) : int'(s.word_no);
        tlen = s.ip_len - 16'(4 * hdr_words_of(s.ihl));
        acc = fold_add(s.sum, {8'h00, s.proto});
        acc = fold_add(acc, tlen);
        r.checksum_value = ~acc;
        if (s.proto == PROTO_TCP)
            r.l4_kind = KIND_TCP;
        else if (s.proto == PROTO_UDP)
            r.l4_kind = KIND_UDP;
        else
            r.l4_kind = KIND_OTHER;
        r.length_error = (s.ihl < MIN_HDR_WORDS) || (2 * received < int'(s.ip_len));
        return r;
    endfunction

    // Fill frame with an IPv4-looking packet: given IHL, total length and protocol,
    // random content everywhere else.
    function automatic void build_frame(input logic [3:0] ihl, input logic [15:0] ip_len,
                                        input logic [7:0] proto, input int nwords);
        logic [15:0] w;
        frame.delete();
        for (int i = 0; i < nwords; i++) begin
            w = 16'($urandom);
            if (i == int'(IDX_IHL))
                w = {4'h4, ihl, w[7:0]};
            else if (i == int'(IDX_TOTAL_LEN))
                w = ip_len;
            else if (i == int'(IDX_PROTOCOL))
                w = {w[15:8], proto};
            frame.push_back(w);
        end
    endfunction

    // Write the word at slot so that the packet checksum comes out correct. With the slot
    // zeroed the verifier would report ~S; putting ~S into the slot makes the sum 0xffff.
    function automatic void seal_checksum(input int slot);
        pkt_state_t  s;
        lcv_result_t r;
        if (slot >= frame.size())
            return;
        frame[slot] = 16'h0000;
        s = '0;
        foreach (frame[i])
            s = take_word(s, frame[i]);
        r = close_packet(s);
        frame[slot] = r.checksum_value;
    endfunction

    // Offer one word after a random gap, wait for the beat, then update the expected state.
    task automatic send_word(input logic [15:0] w, input logic is_last);
        int gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(in_gap_max, 0);
        if (gap > 0) begin
            pkt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt.valid     <= 1'b1;
        pkt.data_word <= w;
        pkt.last      <= is_last;
        do
            @(posedge clk);
        while (!pkt.ready);
        words_accepted++;
        live_state = take_word(live_state, w);
        if (is_last) begin
            pending_results.push_back(close_packet(live_state));
            live_state = '0;
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_word(frame[i], i == frame.size() - 1);
    endtask

    // The final marker arrives before the header is complete: single all-ones and all-zeros
    // words, and a three-word packet that claims far more bytes than it carries.
    task automatic test_early_last();
        frame = '{16'hffff};
        send_frame();
        frame = '{16'h0000};
        send_frame();
        frame = '{16'h4f00, 16'hffff, 16'h1234};
        send_frame();
    endtask

    // IHL of zero and a total length smaller than the header, so the transport length
    // wraps and no transport word is summed.
    task automatic test_short_header();
        frame = '{16'h40ff, 16'h0003, 16'hffff, 16'h0000, 16'h8011,
                  16'h5555, 16'hffff, 16'h0000, 16'hffff, 16'h8001};
        send_frame();
    endtask

    // TCP with a single payload byte: the low byte of the last word must be dropped, and a
    // trailing word past the total length must be ignored.
    task automatic test_odd_tail();
        build_frame(4'd5, 16'd21, PROTO_TCP, 11);
        frame[10] = {frame[10][15:8], 8'ha5};
        frame.push_back(16'hffff);
        send_frame();
    endtask

    // A packet longer than the word counter: words past index 32767 are ignored, and the
    // maximal total length ends on a padded half word at that index.
    task automatic test_index_limit();
        in_gap_max = 0;
        build_frame(4'd5, 16'hffff, PROTO_TCP, LONG_WORDS);
        send_frame();
        in_gap_max = MAX_GAP;
    endtask

    // Mostly well-formed packets with random content, many of them with a correct checksum,
    // plus malformed headers and plain noise.
    task automatic test_random_traffic();
        int          stop_at;
        int          pick;
        int          ihl;
        int          plen;
        int          tot;
        int          nwords;
        int          slot;
        int          k;
        logic [7:0]  proto;
        stop_at = words_accepted + RANDOM_WORDS;
        while (words_accepted < stop_at) begin
            // Roughly one packet in five runs with both sides at full rate.
            if ($urandom_range(4, 0) == 0) begin
                in_gap_max  = 0;
                out_gap_max = 0;
            end else begin
                in_gap_max  = MAX_GAP;
                out_gap_max = MAX_GAP;
            end
            pick = $urandom_range(19, 0);
            proto = (pick < 9) ? PROTO_TCP : (pick < 18) ? PROTO_UDP : 8'($urandom);
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                ihl = ($urandom_range(9, 0) < 7) ? 5 : $urandom_range(15, 6);
                plen = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 49)
                                                   : $urandom_range(48, 0);
                tot = 4 * ihl + plen;
                nwords = 2 * ihl + (plen + 1) / 2;
                build_frame(4'(ihl), 16'(tot), proto, nwords);
                if ($urandom_range(3, 0) != 0) begin
                    if (proto == PROTO_TCP)
                        slot = 2 * ihl + TCP_CSUM_WORD;
                    else if (proto == PROTO_UDP)
                        slot = 2 * ihl + UDP_CSUM_WORD;
                    else
                        slot = 2 * ihl;
                    if (2 * slot + 2 <= tot)
                        seal_checksum(slot);
                end
                // Sometimes pad past the total length, sometimes cut the packet short.
                k = $urandom_range(9, 0);
                if (k == 0) begin
                    repeat ($urandom_range(4, 1))
                        frame.push_back(16'($urandom));
                end else if (k == 1 && frame.size() > 1) begin
                    repeat ($urandom_range(frame.size() > 3 ? 3 : frame.size() - 1, 1))
                        void'(frame.pop_back());
                end
            end else if (pick < 85) begin
                k = $urandom_range(2, 0);
                tot = (k == 0) ? 0 : (k == 1) ? 16'hffff : $urandom_range(80, 0);
                build_frame(4'($urandom_range(15, 0)), 16'(tot), proto, $urandom_range(40, 1));
            end else begin
                build_frame(4'($urandom), 16'($urandom), 8'($urandom), $urandom_range(8, 1));
                frame[0] = 16'($urandom);
            end
            send_frame();
        end
        in_gap_max  = MAX_GAP;
        out_gap_max = MAX_GAP;
    endtask

    // Result side: for each result hold ready low for a random number of cycles once the
    // result shows, so that stalls land on results and back up the input.
    initial begin
        int stall;
        res.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            stall = (out_gap_max == 0) ? 0 : $urandom_range(out_gap_max, 0);
            if (stall > 0) begin
                res.ready <= 1'b0;
                do
                    @(posedge clk);
                while (!res.valid);
                repeat (stall - 1) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res.valid);
        end
    end

    // Compare every result beat with the oldest outstanding expectation.
    always @(posedge clk) begin
        lcv_result_t want;
        if (rst_n && res.valid && res.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h/%0d/%0d", $time,
                         res.checksum_value, res.l4_kind, res.length_error);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (res.checksum_value !== want.checksum_value) begin
                    $display("%0t: checksum_value mismatch, expected %h, got %h", $time,
                             want.checksum_value, res.checksum_value);
                    errors++;
                end
                if (res.l4_kind !== want.l4_kind) begin
                    $display("%0t: l4_kind mismatch, expected %0d, got %0d", $time,
                             want.l4_kind, res.l4_kind);
                    errors++;
                end
                if (res.length_error !== want.length_error) begin
                    $display("%0t: length_error mismatch, expected %0d, got %0d", $time,
                             want.length_error, res.length_error);
                    errors++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL l4_checksum_verifier");
            $finish;
        end
    end

    initial begin
        errors         = 0;
        words_accepted = 0;
        cycle_count    = 0;
        in_gap_max     = MAX_GAP;
        out_gap_max    = MAX_GAP;
        live_state     = '0;
        rst_n         <= 1'b0;
        pkt.valid     <= 1'b0;
        pkt.data_word <= 16'h0000;
        pkt.last      <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_early_last();
        test_short_header();
        test_odd_tail();
        test_index_limit();
        test_random_traffic();

        pkt.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Let any stray beat surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS l4_checksum_verifier");
        else
            $display("FAIL l4_checksum_verifier");
        $finish;
    end

endmodule
